// ----- sv/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// dts_pkg - shared types and constants of the DFA token scanner
//
// Character classes, automaton states, token kinds, keyword table and the
// transaction payload types of both channels.
// ----------------------------------------------------------------------------
package dts_pkg;

    // Input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Token kinds
    localparam logic [2:0] KIND_IDENT   = 3'd0;
    localparam logic [2:0] KIND_NUMBER  = 3'd1;
    localparam logic [2:0] KIND_KEYWORD = 3'd2;
    localparam logic [2:0] KIND_DELIM   = 3'd3;
    localparam logic [2:0] KIND_OPER    = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // Keyword indexes
    localparam logic [2:0] KW_NONE = 3'd7;

    localparam int KW_COUNT      = 7;
    localparam int KW_PREFIX_LEN = 5;

    typedef logic [0:KW_PREFIX_LEN-1][7:0] kw_text_t;

    // Keyword text, first character in entry 0, padded with zeros
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        {"if",    24'h0},
        {"else",   8'h0},
        {"for",   16'h0},
        "while",
        {"int",   16'h0},
        "write",
        {"read",   8'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd5, 3'd4
    };

    typedef enum logic [3:0] {
        CC_ZERO,
        CC_DIGIT,
        CC_LETTER,
        CC_DELIM,
        CC_PLUS,
        CC_MINUS,
        CC_STAR,
        CC_SLASH,
        CC_EQUAL,
        CC_LESS,
        CC_GREATER,
        CC_BANG,
        CC_NONE
    } char_class_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_IDENT,
        ST_NUMBER,
        ST_ZERO,
        ST_DELIM,
        ST_OP,
        ST_OP_EQ,
        ST_BANG,
        ST_SLASH,
        ST_BODY,
        ST_STAR,
        ST_CLOSE,
        ST_DEAD
    } scan_state_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } scan_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] keyword_index;
        logic [7:0] token_length;
        logic [7:0] first_char;
        logic [7:0] second_char;
    } tok_item_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        cls = CC_NONE;
        if (c == "0")
            cls = CC_ZERO;
        else if (c >= "1" && c <= "9")
            cls = CC_DIGIT;
        else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            cls = CC_LETTER;
        else
        begin
            case (c)
                "(", ")", ";", "{", "}", ",": cls = CC_DELIM;
                "+":     cls = CC_PLUS;
                "-":     cls = CC_MINUS;
                "*":     cls = CC_STAR;
                "/":     cls = CC_SLASH;
                "=":     cls = CC_EQUAL;
                "<":     cls = CC_LESS;
                ">":     cls = CC_GREATER;
                "!":     cls = CC_BANG;
                default: cls = CC_NONE;
            endcase
        end
        return cls;
    endfunction

    function automatic scan_state_t next_state(input scan_state_t s, input char_class_t cls);
        scan_state_t n;
        n = ST_DEAD;
        case (s)
            ST_START:
            begin
                case (cls)
                    CC_ZERO:                       n = ST_ZERO;
                    CC_DIGIT:                      n = ST_NUMBER;
                    CC_LETTER:                     n = ST_IDENT;
                    CC_DELIM:                      n = ST_DELIM;
                    CC_PLUS, CC_MINUS, CC_STAR:    n = ST_OP;
                    CC_SLASH:                      n = ST_SLASH;
                    CC_EQUAL, CC_LESS, CC_GREATER: n = ST_OP_EQ;
                    CC_BANG:                       n = ST_BANG;
                    default:                       n = ST_DEAD;
                endcase
            end
            ST_IDENT:
                if (cls == CC_ZERO || cls == CC_DIGIT || cls == CC_LETTER)
                    n = ST_IDENT;
            ST_NUMBER:
                if (cls == CC_ZERO || cls == CC_DIGIT)
                    n = ST_NUMBER;
            ST_OP_EQ, ST_BANG:
                if (cls == CC_EQUAL)
                    n = ST_OP;
            ST_SLASH:
                if (cls == CC_STAR)
                    n = ST_BODY;
            // comment body: anything but a star stays plain text
            ST_BODY:
                n = (cls == CC_STAR) ? ST_STAR : ST_BODY;
            ST_STAR:
            begin
                case (cls)
                    CC_STAR:  n = ST_STAR;
                    CC_SLASH: n = ST_CLOSE;
                    default:  n = ST_BODY;
                endcase
            end
            default: n = ST_DEAD;
        endcase
        return n;
    endfunction

    function automatic logic is_accepting(input scan_state_t s);
        return (s == ST_IDENT) || (s == ST_NUMBER) || (s == ST_ZERO) ||
               (s == ST_DELIM) || (s == ST_OP) || (s == ST_OP_EQ) ||
               (s == ST_CLOSE);
    endfunction

endpackage

// ----- sv/dts_kw_match.sv -----
// ----------------------------------------------------------------------------
// dts_kw_match - keyword lookup
//
// Compares the stored word prefix and a clamped word length against the
// keyword table; returns the matching keyword index or the no-keyword code.
// ----------------------------------------------------------------------------
module dts_kw_match
(
    input  dts_pkg::kw_text_t prefix,
    input  logic [2:0]        len_code,
    output logic [2:0]        kw_index
);

    logic [dts_pkg::KW_COUNT-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < dts_pkg::KW_COUNT; k++)
        begin
            hit[k] = (len_code == dts_pkg::KW_LEN[k]);
            for (int i = 0; i < dts_pkg::KW_PREFIX_LEN; i++)
            begin
                // only characters inside the keyword length count
                if (i < int'(dts_pkg::KW_LEN[k]) && prefix[i] != dts_pkg::KW_TEXT[k][i])
                    hit[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        kw_index = dts_pkg::KW_NONE;
        for (int k = dts_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (hit[k])
                kw_index = 3'(k);
        end
    end

endmodule

// ----- sv/dfa_token_scanner.sv -----
// ----------------------------------------------------------------------------
// dfa_token_scanner - lexical analyzer driven by a 13-state automaton
//
// Channel  Role    Handshake            Payload
// scan     sink    scan_valid/stall     dts_pkg::scan_item_t {cmd, ch}
// tok      source  tok_valid/stall      dts_pkg::tok_item_t  {kind, keyword_index,
//                                        token_length, first_char, second_char}
//
// One character transaction per cycle while scan_stall is low: the automaton
// step, keyword compare and token build sit between the scan state registers
// and the token register. A transaction that ends a token writes it into the
// token register, or into the skid register behind it while tok is stalled,
// which keeps the scan side running; scan_stall rises only when both hold a token.
// Reset (rst_n low, asynchronous) returns the automaton to start, empty word.
// ----------------------------------------------------------------------------
module dfa_token_scanner
#(
    parameter int MAX_TOKEN_LEN = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                scan_valid,
    output logic                scan_stall,
    input  dts_pkg::scan_item_t scan_item,
    output logic                tok_valid,
    input  logic                tok_stall,
    output dts_pkg::tok_item_t  tok_item
);

    localparam int LEN_CAP = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
    localparam int LEN_W   = $clog2(LEN_CAP + 2);

    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
    localparam logic [LEN_W-1:0] LEN_SAT_V = LEN_W'(LEN_CAP + 1);

    dts_pkg::scan_state_t state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    dts_pkg::kw_text_t    prefix_reg, prefix_next;

    logic                 out_valid_reg, out_valid_next;
    dts_pkg::tok_item_t   out_reg, out_next;
    logic                 skid_valid_reg, skid_valid_next;
    dts_pkg::tok_item_t   skid_reg, skid_next;

    dts_pkg::char_class_t cls;
    dts_pkg::scan_state_t step;
    logic                 accept;
    logic                 extend;
    logic                 emit;
    logic                 space;
    logic                 out_fire;
    logic [2:0]           len_code;
    logic [2:0]           kw_index;
    dts_pkg::tok_item_t   tok;

    assign accept   = scan_valid && !scan_stall;
    assign out_fire = out_valid_reg && !tok_stall;

    assign cls    = dts_pkg::char_class(scan_item.ch);
    assign step   = dts_pkg::next_state(state_reg, cls);
    assign extend = (scan_item.cmd == dts_pkg::CMD_CHAR) && (step != dts_pkg::ST_DEAD);
    assign space  = (scan_item.ch == 8'h20) || (scan_item.ch == 8'h09) ||
                    (scan_item.ch == 8'h0A);

    // a closed comment and an empty word produce no token
    assign emit = accept && !extend && (len_reg != '0) && (state_reg != dts_pkg::ST_CLOSE);

    assign len_code = (len_reg > LEN_W'(6)) ? 3'd7 : 3'(len_reg);

    dts_kw_match u_kw_match
    (
        .prefix   (prefix_reg),
        .len_code (len_code),
        .kw_index (kw_index)
    );

    always_comb
    begin
        tok.keyword_index = dts_pkg::KW_NONE;
        tok.kind          = dts_pkg::KIND_ERROR;
        if (dts_pkg::is_accepting(state_reg))
        begin
            tok.keyword_index = kw_index;
            if (kw_index != dts_pkg::KW_NONE)
                tok.kind = dts_pkg::KIND_KEYWORD;
            else if (state_reg == dts_pkg::ST_IDENT)
                tok.kind = dts_pkg::KIND_IDENT;
            else if (state_reg == dts_pkg::ST_NUMBER || state_reg == dts_pkg::ST_ZERO)
                tok.kind = dts_pkg::KIND_NUMBER;
            else if (state_reg == dts_pkg::ST_DELIM)
                tok.kind = dts_pkg::KIND_DELIM;
            else
                tok.kind = dts_pkg::KIND_OPER;
        end
        tok.token_length = (len_reg > LEN_CAP_V) ? 8'(LEN_CAP_V) : 8'(len_reg);
        tok.first_char   = prefix_reg[0];
        tok.second_char  = (len_reg >= LEN_W'(2)) ? prefix_reg[1] : 8'h00;
    end

    // automaton and word tracking
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        if (accept)
        begin
            if (scan_item.cmd == dts_pkg::CMD_END)
            begin
                state_next = dts_pkg::ST_START;
                len_next   = '0;
            end
            else if (extend)
            begin
                state_next = step;
                for (int i = 0; i < dts_pkg::KW_PREFIX_LEN; i++)
                begin
                    if (len_reg == LEN_W'(i))
                        prefix_next[i] = scan_item.ch;
                end
                if (len_reg < LEN_SAT_V)
                    len_next = len_reg + LEN_W'(1);
            end
            else if (space)
            begin
                state_next = dts_pkg::ST_START;
                len_next   = '0;
            end
            else
            begin
                // rejected character opens a new word
                state_next     = dts_pkg::next_state(dts_pkg::ST_START, cls);
                len_next       = LEN_W'(1);
                prefix_next[0] = scan_item.ch;
            end
        end
    end

    // token register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_next       = tok;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = tok;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dts_pkg::ST_START;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // hold payload without reset
    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        out_reg    <= out_next;
        skid_reg   <= skid_next;
    end

    assign scan_stall = skid_valid_reg;
    assign tok_valid  = out_valid_reg;
    assign tok_item   = out_reg;

endmodule
